[sv/qsm3_pkg.sv]
// Shared constants, types and value conversions for the median-of-three quicksort block.
`default_nettype none

package qsm3_pkg;

    // Store geometry and element width
    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int VALUE_W    = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SPAN_W     = 2 * IDX_W;

    // One sorted element handed from the engine to the output stage
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
        logic               last;
    } emit_t;

    // Port value to stored element: sign-extend, then keep DATA_WIDTH bits
    function automatic logic [DATA_WIDTH-1:0] to_store(input logic [VALUE_W-1:0] v);
        logic [63:0] w;
        w = 64'(signed'(v));
        return w[DATA_WIDTH-1:0];
    endfunction

    // Stored element to port value: low bits of the element, zero filled
    function automatic logic [VALUE_W-1:0] to_result(input logic [DATA_WIDTH-1:0] e);
        logic [63:0] w;
        w = 64'(e);
        return w[VALUE_W-1:0];
    endfunction

endpackage

`default_nettype wire

[sv/qsm3_elem_if.sv]
// Request channel carrying unsorted elements into the block.
`default_nettype none

interface qsm3_elem_if;
    import qsm3_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               last_item;

    modport source (output valid, output value, output last_item, input ready);
    modport sink   (input valid, input value, input last_item, output ready);
endinterface

`default_nettype wire

[sv/qsm3_result_if.sv]
// Request channel carrying sorted elements out of the block.
`default_nettype none

interface qsm3_result_if;
    import qsm3_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] sorted_value;
    logic               last_result;

    modport source (output valid, output sorted_value, output last_result, input ready);
    modport sink   (input valid, input sorted_value, input last_result, output ready);
endinterface

`default_nettype wire

[sv/qsm3_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module qsm3_ram #(
    parameter int WIDTH = 32,
    parameter int WORDS = 64,
    localparam int AddrW = $clog2(WORDS)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AddrW-1:0] waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AddrW-1:0] raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [WORDS];

    // Write port and registered read port; read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/qsm3_engine.sv]
// Load, quicksort and readout sequencer around one shared signed comparator.
`default_nettype none

module qsm3_engine (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [qsm3_pkg::VALUE_W-1:0] in_value,
    input  wire logic                    in_last,
    output qsm3_pkg::emit_t              emit,
    input  wire logic                    emit_ready
);
    import qsm3_pkg::*;

    typedef enum logic [19:0] {
        S_LOAD  = 20'h00001,
        S_PUSH0 = 20'h00002,
        S_POP   = 20'h00004,
        S_POPW  = 20'h00008,
        S_RA    = 20'h00010,
        S_RB    = 20'h00020,
        S_RC    = 20'h00040,
        S_RD    = 20'h00080,
        S_SW    = 20'h00100,
        S_PJ    = 20'h00200,
        S_PC    = 20'h00400,
        S_PI    = 20'h00800,
        S_PW    = 20'h01000,
        S_FI    = 20'h02000,
        S_FR    = 20'h04000,
        S_FW    = 20'h08000,
        S_PU1   = 20'h10000,
        S_PU2   = 20'h20000,
        S_ERD   = 20'h40000,
        S_EWT   = 20'h80000
    } state_t;

    // Control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  top_reg, top_next;

    // Working registers of the current range
    logic [IDX_W-1:0]      lo_reg, lo_next;
    logic [IDX_W-1:0]      hi_reg, hi_next;
    logic [IDX_W-1:0]      mid_reg, mid_next;
    logic [IDX_W-1:0]      j_reg, j_next;
    logic [IDX_W-1:0]      ip_reg, ip_next;
    logic [IDX_W-1:0]      k_reg, k_next;
    logic [DATA_WIDTH-1:0] a_reg, a_next;
    logic [DATA_WIDTH-1:0] b_reg, b_next;
    logic [DATA_WIDTH-1:0] c_reg, c_next;
    logic [DATA_WIDTH-1:0] pivot_reg, pivot_next;
    logic                  ab_reg, ab_next;
    logic                  m1_reg, m1_next;

    // Memory ports
    logic                  st_we, st_re;
    logic [IDX_W-1:0]      st_waddr, st_raddr;
    logic [DATA_WIDTH-1:0] st_wdata, st_rdata;
    logic                  sk_we, sk_re;
    logic [IDX_W-1:0]      sk_waddr, sk_raddr;
    logic [SPAN_W-1:0]     sk_wdata, sk_rdata;

    // Shared comparator
    logic [DATA_WIDTH-1:0] cmp_x, cmp_y;
    logic                  cmp_lt;

    // Index arithmetic
    logic [IDX_W:0]   j_inc, ip_inc, lo_inc, mid_sum;
    logic [IDX_W-1:0] ip_dec;
    logic [CNT_W-1:0] cnt_inc, cnt_dec, top_inc, top_dec, k_inc;
    logic             j_more, out_last;

    qsm3_ram #(.WIDTH(DATA_WIDTH), .WORDS(DEPTH)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    qsm3_ram #(.WIDTH(SPAN_W), .WORDS(DEPTH)) u_stack (
        .clk   (clk),
        .we    (sk_we),
        .waddr (sk_waddr),
        .wdata (sk_wdata),
        .re    (sk_re),
        .raddr (sk_raddr),
        .rdata (sk_rdata)
    );

    assign cmp_lt = $signed(cmp_x) < $signed(cmp_y);

    assign j_inc    = {1'b0, j_reg} + 1'b1;
    assign ip_inc   = {1'b0, ip_reg} + 1'b1;
    assign lo_inc   = {1'b0, lo_reg} + 1'b1;
    assign ip_dec   = ip_reg - 1'b1;
    assign mid_sum  = {1'b0, sk_rdata[SPAN_W-1:IDX_W]} + {1'b0, sk_rdata[IDX_W-1:0]};
    assign cnt_inc  = cnt_reg + 1'b1;
    assign cnt_dec  = cnt_reg - 1'b1;
    assign top_inc  = top_reg + 1'b1;
    assign top_dec  = top_reg - 1'b1;
    assign k_inc    = CNT_W'(k_reg) + 1'b1;
    assign j_more   = j_inc < {1'b0, hi_reg};
    assign out_last = k_inc == cnt_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        top_next   = top_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        j_next     = j_reg;
        ip_next    = ip_reg;
        k_next     = k_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        pivot_next = pivot_reg;
        ab_next    = ab_reg;
        m1_next    = m1_reg;

        st_we    = 1'b0;
        st_waddr = j_reg;
        st_wdata = b_reg;
        st_re    = 1'b0;
        st_raddr = j_reg;
        sk_we    = 1'b0;
        sk_waddr = top_reg[IDX_W-1:0];
        sk_wdata = {lo_reg, hi_reg};
        sk_re    = 1'b0;
        sk_raddr = top_dec[IDX_W-1:0];
        cmp_x    = a_reg;
        cmp_y    = b_reg;

        in_ready    = 1'b0;
        emit.valid  = 1'b0;
        emit.value  = to_result(st_rdata);
        emit.last   = out_last;

        case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                st_waddr = cnt_reg[IDX_W-1:0];
                st_wdata = to_store(in_value);
                if (in_valid)
                begin
                    st_we    = 1'b1;
                    cnt_next = cnt_inc;
                    if (in_last || cnt_inc == CNT_W'(DEPTH))
                    begin
                        state_next = S_PUSH0;
                    end
                end
            end
            S_PUSH0:
            begin
                // whole set as the first range, when it has two or more
                sk_wdata = {IDX_W'(0), cnt_dec[IDX_W-1:0]};
                if (cnt_reg > CNT_W'(1))
                begin
                    sk_we    = 1'b1;
                    top_next = top_inc;
                end
                state_next = S_POP;
            end
            S_POP:
            begin
                if (top_reg == '0)
                begin
                    k_next     = '0;
                    state_next = S_ERD;
                end
                else
                begin
                    sk_re      = 1'b1;
                    top_next   = top_dec;
                    state_next = S_POPW;
                end
            end
            S_POPW:
            begin
                lo_next    = sk_rdata[SPAN_W-1:IDX_W];
                hi_next    = sk_rdata[IDX_W-1:0];
                mid_next   = mid_sum[IDX_W:1];
                st_re      = 1'b1;
                st_raddr   = sk_rdata[SPAN_W-1:IDX_W];
                state_next = S_RA;
            end
            S_RA:
            begin
                a_next     = st_rdata;
                st_re      = 1'b1;
                st_raddr   = mid_reg;
                state_next = S_RB;
            end
            S_RB:
            begin
                cmp_x      = a_reg;
                cmp_y      = st_rdata;
                ab_next    = cmp_lt;
                b_next     = st_rdata;
                st_re      = 1'b1;
                st_raddr   = hi_reg;
                state_next = S_RC;
            end
            S_RC:
            begin
                // middle is the median if it sits between first and last
                c_next     = st_rdata;
                cmp_x      = ab_reg ? b_reg : st_rdata;
                cmp_y      = ab_reg ? st_rdata : b_reg;
                m1_next    = cmp_lt;
                state_next = S_RD;
            end
            S_RD:
            begin
                cmp_x    = ab_reg ? a_reg : c_reg;
                cmp_y    = ab_reg ? c_reg : a_reg;
                st_we    = 1'b1;
                st_waddr = hi_reg;
                if (m1_reg)
                begin
                    st_wdata   = b_reg;
                    pivot_next = b_reg;
                    mid_next   = mid_reg;
                end
                else if (cmp_lt)
                begin
                    st_wdata   = c_reg;
                    pivot_next = c_reg;
                    mid_next   = hi_reg;
                end
                else
                begin
                    st_wdata   = a_reg;
                    pivot_next = a_reg;
                    mid_next   = lo_reg;
                end
                state_next = S_SW;
            end
            S_SW:
            begin
                // second half of the pivot swap into the last slot
                st_we      = 1'b1;
                st_waddr   = mid_reg;
                st_wdata   = c_reg;
                ip_next    = lo_reg;
                j_next     = lo_reg;
                state_next = S_PJ;
            end
            S_PJ:
            begin
                st_re      = 1'b1;
                st_raddr   = j_reg;
                state_next = S_PC;
            end
            S_PC:
            begin
                cmp_x  = pivot_reg;
                cmp_y  = st_rdata;
                b_next = st_rdata;
                if (cmp_lt)
                begin
                    j_next     = j_inc[IDX_W-1:0];
                    state_next = j_more ? S_PJ : S_FI;
                end
                else
                begin
                    st_re      = 1'b1;
                    st_raddr   = ip_reg;
                    state_next = S_PI;
                end
            end
            S_PI:
            begin
                st_we      = 1'b1;
                st_waddr   = j_reg;
                st_wdata   = st_rdata;
                state_next = S_PW;
            end
            S_PW:
            begin
                st_we      = 1'b1;
                st_waddr   = ip_reg;
                st_wdata   = b_reg;
                ip_next    = ip_inc[IDX_W-1:0];
                j_next     = j_inc[IDX_W-1:0];
                state_next = j_more ? S_PJ : S_FI;
            end
            S_FI:
            begin
                st_re      = 1'b1;
                st_raddr   = ip_reg;
                state_next = S_FR;
            end
            S_FR:
            begin
                st_we      = 1'b1;
                st_waddr   = hi_reg;
                st_wdata   = st_rdata;
                state_next = S_FW;
            end
            S_FW:
            begin
                st_we      = 1'b1;
                st_waddr   = ip_reg;
                st_wdata   = pivot_reg;
                state_next = S_PU1;
            end
            S_PU1:
            begin
                // upper part goes below the lower so the lower pops first
                sk_wdata = {ip_inc[IDX_W-1:0], hi_reg};
                if (ip_inc < {1'b0, hi_reg} && top_reg < CNT_W'(DEPTH))
                begin
                    sk_we    = 1'b1;
                    top_next = top_inc;
                end
                state_next = S_PU2;
            end
            S_PU2:
            begin
                sk_wdata = {lo_reg, ip_dec};
                if (lo_inc < {1'b0, ip_reg} && top_reg < CNT_W'(DEPTH))
                begin
                    sk_we    = 1'b1;
                    top_next = top_inc;
                end
                state_next = S_POP;
            end
            S_ERD:
            begin
                st_re      = 1'b1;
                st_raddr   = k_reg;
                state_next = S_EWT;
            end
            S_EWT:
            begin
                emit.valid = 1'b1;
                if (emit_ready)
                begin
                    if (out_last)
                    begin
                        cnt_next   = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_inc[IDX_W-1:0];
                        state_next = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
                cnt_next   = '0;
                top_next   = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            top_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            top_reg   <= top_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        j_reg     <= j_next;
        ip_reg    <= ip_next;
        k_reg     <= k_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        pivot_reg <= pivot_next;
        ab_reg    <= ab_next;
        m1_reg    <= m1_next;
    end

    // Disjoint ranges of two or more never fill more than half the stack
    assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= CNT_W'(DEPTH / 2))
        else $error("range stack deeper than half the store");

    // A popped range always holds at least two elements
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RA) |-> (lo_reg < hi_reg))
        else $error("popped range is empty or single");

    // Partition boundary never runs ahead of the scan index
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PC) |-> (ip_reg <= j_reg && j_reg < hi_reg))
        else $error("partition indices out of order");

    // Handing off the final element restarts loading with an empty store
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit.valid && emit_ready && emit.last) |=> (state_reg == S_LOAD && cnt_reg == '0))
        else $error("run did not return to loading");

endmodule

`default_nettype wire

[sv/quicksort_median_of_three_core.sv]
// Top level: element channel into the sort engine, registered result channel out.
// Loading: one element per cycle; elements is ready only while a set is loading.
// Sorting: per range a pop, median-of-three pivot selection, a scan that swaps each element
//   not above the pivot into the lower part, the final pivot swap and the pushes of both parts,
//   all through one store read port and one comparator.
// Readout: each element is read from the store, then held until the output register takes it.
// Reset: asynchronous, active low; clears sequencer, element count, stack top and the output
//   valid bit. Store and stack contents are not cleared and are always written before read.
`default_nettype none

module quicksort_median_of_three_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    qsm3_elem_if.sink   elements,
    qsm3_result_if.source results
);
    import qsm3_pkg::*;

    emit_t              emit;
    logic               emit_ready;
    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    logic               out_last_reg, out_last_next;

    qsm3_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (elements.valid),
        .in_ready   (elements.ready),
        .in_value   (elements.value),
        .in_last    (elements.last_item),
        .emit       (emit),
        .emit_ready (emit_ready)
    );

    // Output register: refills in the cycle it is drained
    assign emit_ready = !out_valid_reg || results.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        if (emit.valid && emit_ready)
        begin
            out_valid_next = 1'b1;
            out_value_next = emit.value;
            out_last_next  = emit.last;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign results.valid        = out_valid_reg;
    assign results.sorted_value = out_value_reg;
    assign results.last_result  = out_last_reg;

endmodule

`default_nettype wire
